// ----- hw/rtl/masked_bitsliced_aes_sbox_assert.svh -----
// Assertion macros shared by the masked S-box files.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef MASKED_BITSLICED_AES_SBOX_ASSERT_SVH
`define MASKED_BITSLICED_AES_SBOX_ASSERT_SVH

// Same-cycle implication.
`define MSBOX_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSBOX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/msbox_pkg.sv -----
package msbox_pkg;

    localparam int NUM_SHARES = 3;
    localparam int NUM_PLANES = 8;
    localparam int NUM_LANES  = 8;
    localparam int NUM_ANDS   = 32;
    localparam int NUM_DRAWS  = NUM_ANDS * NUM_SHARES;
    localparam int STATE_W    = 96;
    localparam int RAND_W     = NUM_DRAWS * 8;
    localparam int SHARE_W    = NUM_PLANES * NUM_LANES;

    localparam logic [31:0] PRNG_X_INIT = 32'd123456789;
    localparam logic [31:0] PRNG_Y_INIT = 32'd362436069;
    localparam logic [31:0] PRNG_Z_INIT = 32'd521288629;

    typedef logic [NUM_SHARES-1:0] trip_t;

    // One xorshift96 draw; state packs {z, y, x}.
    function automatic logic [STATE_W-1:0] prng_step(input logic [STATE_W-1:0] s);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = s[31:0];
        y = s[63:32];
        z = s[95:64];
        x = x ^ (x << 16);
        x = x ^ (x >> 5);
        x = x ^ (x << 1);
        return {x ^ y ^ z, z, y};
    endfunction

    // The generator is linear over GF(2), so the effect of each state bit
    // on all draws of one beat is a constant column.
    function automatic logic [RAND_W-1:0] rand_col(input int j);
        logic [STATE_W-1:0] s;
        logic [RAND_W-1:0]  r;
        s = STATE_W'(1) << j;
        r = '0;
        for (int i = 0; i < NUM_DRAWS; i++)
        begin
            s = prng_step(s);
            r[i*8 +: 8] = s[71:64];
        end
        return r;
    endfunction

    function automatic logic [STATE_W-1:0] next_col(input int j);
        logic [STATE_W-1:0] s;
        s = STATE_W'(1) << j;
        for (int i = 0; i < NUM_DRAWS; i++)
        begin
            s = prng_step(s);
        end
        return s;
    endfunction

    // Three-share ISW AND with pair order (0,1), (0,2), (1,2).
    function automatic trip_t isw_and(input trip_t a, input trip_t b, input trip_t r);
        trip_t c;
        c = a & b;
        c[0] = c[0] ^ r[0];
        c[1] = c[1] ^ r[0] ^ (a[0] & b[1]) ^ (a[1] & b[0]);
        c[0] = c[0] ^ r[1];
        c[2] = c[2] ^ r[1] ^ (a[0] & b[2]) ^ (a[2] & b[0]);
        c[1] = c[1] ^ r[2];
        c[2] = c[2] ^ r[2] ^ (a[1] & b[2]) ^ (a[2] & b[1]);
        return c;
    endfunction

    function automatic trip_t tnot(input trip_t a);
        return a ^ trip_t'(1);
    endfunction

endpackage

// ----- hw/rtl/msbox_in_if.sv -----
interface msbox_in_if import msbox_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SHARE_W-1:0] share0_in;
    logic [SHARE_W-1:0] share1_in;
    logic [SHARE_W-1:0] share2_in;

    modport source (output valid, output share0_in, output share1_in, output share2_in,
                    input ready);
    modport sink (input valid, input share0_in, input share1_in, input share2_in,
                  output ready);
endinterface

// ----- hw/rtl/msbox_out_if.sv -----
interface msbox_out_if import msbox_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SHARE_W-1:0] share0_out;
    logic [SHARE_W-1:0] share1_out;
    logic [SHARE_W-1:0] share2_out;

    modport source (output valid, output share0_out, output share1_out, output share2_out,
                    input ready);
    modport sink (input valid, input share0_out, input share1_out, input share2_out,
                  output ready);
endinterface

// ----- hw/rtl/masked_bitsliced_aes_sbox.sv -----
// Three-share masked AES S-box over eight bitsliced lanes. One beat carries
// three 64-bit shares (byte k = bit-plane k, bit b = lane b) and yields one
// beat of three output shares that XOR to the S-box of the unmasked lanes.
// Each beat is evaluated by eight parallel lane circuits in the cycle it is
// accepted and lands in the output register, so a new beat is taken every
// cycle while the output side keeps up. The internal xorshift96
// generator supplies all 96 random bytes of a beat at once and steps by 96
// draws per accepted beat; it restarts from its fixed seed at reset only.
`include "masked_bitsliced_aes_sbox_assert.svh"

module masked_bitsliced_aes_sbox import msbox_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    msbox_in_if.sink    in_ch,
    msbox_out_if.source out_ch
);

    logic               accept;
    logic [RAND_W-1:0]  rnd_bits;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SHARE_W-1:0] out_sh_reg [NUM_SHARES];
    logic [SHARE_W-1:0] merged [NUM_SHARES];
    logic [SHARE_W-1:0] in_sh [NUM_SHARES];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_sh[0]    = in_ch.share0_in;
    assign in_sh[1]    = in_ch.share1_in;
    assign in_sh[2]    = in_ch.share2_in;

    msbox_prng u_prng
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .rnd_bits (rnd_bits)
    );

    genvar b, k, s, g;
    generate
        for (b = 0; b < NUM_LANES; b++)
        begin : g_lane
            trip_t [NUM_PLANES-1:0] lx;
            trip_t [NUM_PLANES-1:0] ls;
            logic  [NUM_DRAWS-1:0]  lr;

            for (g = 0; g < NUM_DRAWS; g++)
            begin : g_rnd
                assign lr[g] = rnd_bits[g*8 + b];
            end

            for (k = 0; k < NUM_PLANES; k++)
            begin : g_plane
                for (s = 0; s < NUM_SHARES; s++)
                begin : g_sh
                    assign lx[k][s]              = in_sh[s][k*NUM_LANES + b];
                    assign merged[s][k*NUM_LANES + b] = ls[k][s];
                end
            end

            msbox_lane u_lane
            (
                .x_in  (lx),
                .rnd   (lr),
                .s_out (ls)
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_SHARES; i++)
            begin
                out_sh_reg[i] <= merged[i];
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.share0_out = out_sh_reg[0];
    assign out_ch.share1_out = out_sh_reg[1];
    assign out_ch.share2_out = out_sh_reg[2];

    `MSBOX_ASSERT_NEXT(a_accept_loads, accept, out_valid_reg, "accepted beat did not reach output")
    `MSBOX_ASSERT_NEXT(a_stall_keeps, out_valid_reg && !out_ch.ready, out_valid_reg, "stalled result dropped")
    `MSBOX_ASSERT_IMPL(a_no_overrun, out_valid_reg && !out_ch.ready, !accept, "beat taken over a pending result")

endmodule

// ----- hw/rtl/msbox_prng.sv -----
`include "masked_bitsliced_aes_sbox_assert.svh"

module msbox_prng import msbox_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    output logic [RAND_W-1:0] rnd_bits
);

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [RAND_W-1:0]  rand_term [STATE_W];
    logic [STATE_W-1:0] next_term [STATE_W];

    // Each beat consumes a whole block of draws, computed as a parity
    // product of the state with constant columns.
    genvar j;
    generate
        for (j = 0; j < STATE_W; j++)
        begin : g_col
            localparam logic [RAND_W-1:0]  RC = rand_col(j);
            localparam logic [STATE_W-1:0] NC = next_col(j);
            assign rand_term[j] = state_reg[j] ? RC : '0;
            assign next_term[j] = state_reg[j] ? NC : '0;
        end
    endgenerate

    always_comb
    begin
        rnd_bits   = '0;
        state_next = '0;
        for (int i = 0; i < STATE_W; i++)
        begin
            rnd_bits   = rnd_bits ^ rand_term[i];
            state_next = state_next ^ next_term[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= {PRNG_Z_INIT, PRNG_Y_INIT, PRNG_X_INIT};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    `MSBOX_ASSERT_NEXT(a_prng_hold, !advance, $stable(state_reg), "PRNG moved without a beat")
    `MSBOX_ASSERT_IMPL(a_prng_nonzero, 1'b1, state_reg != '0, "PRNG state collapsed to zero")
    `MSBOX_ASSERT_NEXT(a_prng_load, advance, state_reg == $past(state_next), "PRNG missed a load")

endmodule

// ----- hw/rtl/msbox_lane.sv -----
module msbox_lane import msbox_pkg::*;
(
    input  trip_t [NUM_PLANES-1:0]   x_in,
    input  logic  [NUM_DRAWS-1:0]    rnd,
    output trip_t [NUM_PLANES-1:0]   s_out
);

    trip_t x [8];
    trip_t y [22];
    trip_t t [68];
    trip_t z [18];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            x[k] = x_in[k];
        end
        for (int k = 0; k < 22; k++)
        begin
            y[k] = '0;
        end
        for (int k = 0; k < 68; k++)
        begin
            t[k] = '0;
        end

        y[14] = x[3] ^ x[5];
        y[13] = x[0] ^ x[6];
        y[12] = y[13] ^ y[14];
        y[9]  = x[0] ^ x[3];
        y[8]  = x[0] ^ x[5];
        t[0]  = x[1] ^ x[2];
        y[1]  = t[0] ^ x[7];
        y[4]  = y[1] ^ x[3];
        y[2]  = y[1] ^ x[0];
        y[5]  = y[1] ^ x[6];
        t[1]  = x[4] ^ y[12];
        y[3]  = y[5] ^ y[8];
        y[15] = t[1] ^ x[5];
        y[20] = t[1] ^ x[1];
        y[6]  = y[15] ^ x[7];
        y[10] = y[15] ^ t[0];
        y[11] = y[20] ^ y[9];
        y[7]  = x[7] ^ y[11];
        y[17] = y[10] ^ y[11];
        y[19] = y[10] ^ y[8];
        y[16] = t[0] ^ y[11];
        y[21] = y[13] ^ y[16];
        y[18] = x[0] ^ y[16];

        // Gadget k takes random bits 3k..3k+2.
        t[2]  = isw_and(y[12], y[15], rnd[0*3 +: 3]);
        t[3]  = isw_and(y[3], y[6], rnd[1*3 +: 3]);
        t[5]  = isw_and(y[4], x[7], rnd[2*3 +: 3]);
        t[7]  = isw_and(y[13], y[16], rnd[3*3 +: 3]);
        t[8]  = isw_and(y[5], y[1], rnd[4*3 +: 3]);
        t[10] = isw_and(y[2], y[7], rnd[5*3 +: 3]);
        t[12] = isw_and(y[9], y[11], rnd[6*3 +: 3]);
        t[13] = isw_and(y[14], y[17], rnd[7*3 +: 3]);
        t[4]  = t[3] ^ t[2];
        t[6]  = t[5] ^ t[2];
        t[9]  = t[8] ^ t[7];
        t[11] = t[10] ^ t[7];
        t[14] = t[13] ^ t[12];
        t[17] = t[4] ^ t[14];
        t[19] = t[9] ^ t[14];
        t[21] = t[17] ^ y[20];
        t[23] = t[19] ^ y[21];
        t[15] = isw_and(y[8], y[10], rnd[8*3 +: 3]);
        t[26] = isw_and(t[21], t[23], rnd[9*3 +: 3]);
        t[16] = t[15] ^ t[12];
        t[18] = t[6] ^ t[16];
        t[20] = t[11] ^ t[16];
        t[24] = t[20] ^ y[18];
        t[30] = t[23] ^ t[24];
        t[22] = t[18] ^ y[19];
        t[25] = t[21] ^ t[22];
        t[27] = t[24] ^ t[26];
        t[31] = t[22] ^ t[26];
        t[28] = isw_and(t[25], t[27], rnd[10*3 +: 3]);
        t[32] = isw_and(t[31], t[30], rnd[11*3 +: 3]);
        t[29] = t[28] ^ t[22];
        t[33] = t[32] ^ t[24];
        t[34] = t[23] ^ t[33];
        t[35] = t[27] ^ t[33];
        t[42] = t[29] ^ t[33];
        z[14] = isw_and(t[29], y[2], rnd[12*3 +: 3]);
        t[36] = isw_and(t[24], t[35], rnd[13*3 +: 3]);
        t[37] = t[36] ^ t[34];
        t[38] = t[27] ^ t[36];
        t[39] = isw_and(t[29], t[38], rnd[14*3 +: 3]);
        z[5]  = isw_and(t[29], y[7], rnd[15*3 +: 3]);
        t[44] = t[33] ^ t[37];
        t[40] = t[25] ^ t[39];
        t[41] = t[40] ^ t[37];
        t[43] = t[29] ^ t[40];
        t[45] = t[42] ^ t[41];
        z[0]  = isw_and(t[44], y[15], rnd[16*3 +: 3]);
        z[1]  = isw_and(t[37], y[6], rnd[17*3 +: 3]);
        z[2]  = isw_and(t[33], x[7], rnd[18*3 +: 3]);
        z[3]  = isw_and(t[43], y[16], rnd[19*3 +: 3]);
        z[4]  = isw_and(t[40], y[1], rnd[20*3 +: 3]);
        z[6]  = isw_and(t[42], y[11], rnd[21*3 +: 3]);
        z[7]  = isw_and(t[45], y[17], rnd[22*3 +: 3]);
        z[8]  = isw_and(t[41], y[10], rnd[23*3 +: 3]);
        z[9]  = isw_and(t[44], y[12], rnd[24*3 +: 3]);
        z[10] = isw_and(t[37], y[3], rnd[25*3 +: 3]);
        z[11] = isw_and(t[33], y[4], rnd[26*3 +: 3]);
        z[12] = isw_and(t[43], y[13], rnd[27*3 +: 3]);
        z[13] = isw_and(t[40], y[5], rnd[28*3 +: 3]);
        z[15] = isw_and(t[42], y[9], rnd[29*3 +: 3]);
        z[16] = isw_and(t[45], y[14], rnd[30*3 +: 3]);
        z[17] = isw_and(t[41], y[8], rnd[31*3 +: 3]);

        t[46] = z[15] ^ z[16];
        t[55] = z[16] ^ z[17];
        t[52] = z[7] ^ z[8];
        t[54] = z[6] ^ z[7];
        t[58] = z[4] ^ t[46];
        t[59] = z[3] ^ t[54];
        t[64] = z[4] ^ t[59];
        t[47] = z[10] ^ z[11];
        t[49] = z[9] ^ z[10];
        t[63] = t[49] ^ t[58];
        t[66] = z[1] ^ t[63];
        t[62] = t[52] ^ t[58];
        t[53] = z[0] ^ z[3];
        t[50] = z[2] ^ z[12];
        t[57] = t[50] ^ t[53];
        t[60] = t[46] ^ t[57];
        t[61] = z[14] ^ t[57];
        t[65] = t[61] ^ t[62];
        t[51] = z[2] ^ z[5];
        t[67] = t[64] ^ t[65];
        t[48] = z[5] ^ z[13];
        t[56] = z[12] ^ t[48];

        s_out[0] = t[59] ^ t[63];
        s_out[4] = t[51] ^ t[66];
        s_out[5] = t[47] ^ t[65];
        s_out[2] = tnot(t[55] ^ t[67]);
        s_out[3] = t[53] ^ t[66];
        s_out[1] = tnot(t[64] ^ t[53] ^ t[66]);
        s_out[6] = tnot(t[56] ^ t[62]);
        s_out[7] = tnot(t[48] ^ t[60]);
    end

endmodule
